### rtl/drop_oldest_message_queue_core_assert.svh
// Assertion helpers used by the queue datapath.
`ifndef DROP_OLDEST_MESSAGE_QUEUE_CORE_ASSERT_SVH
`define DROP_OLDEST_MESSAGE_QUEUE_CORE_ASSERT_SVH

// Property that must hold at every edge out of reset.
`define DOM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define DOM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DOM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dom_pkg.sv
`default_nettype none

package dom_pkg;

  // Queue geometry; the ring keeps one spare slot
  localparam int QueueDepth = 32;
  localparam int RingSlots  = QueueDepth + 1;
  localparam int PtrW       = $clog2(RingSlots);

  // Field widths
  localparam int ModeW  = 2;
  localparam int TagW   = 16;
  localparam int LenW   = 24;
  localparam int CntW   = 6;
  localparam int TotW   = LenW + 1;
  localparam int CfgIdxW = 1;

  // Register reset values
  localparam logic [CntW-1:0] MaxMsgReset   = CntW'(32);
  localparam logic [LenW-1:0] MaxBytesReset = LenW'(262144);

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH = 2'd0,
    MODE_POP  = 2'd1,
    MODE_WILL = 2'd2,
    MODE_SUB  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SUB    = 2'd1,
    KIND_WILL   = 2'd2,
    KIND_QUEUED = 2'd3
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MAX_MESSAGES = 1'd0,
    REG_MAX_BYTES    = 1'd1
  } cfg_reg_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic push_write;
    logic drop;
    logic pop;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic  in_valid;
    mode_e in_mode;
    logic  lim_hit;
    logic  over_budget;
    logic  out_free;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/dom_if.sv
`default_nettype none

// Input beat: one queue operation
interface dom_in_if;
  logic                             valid;
  logic                             ready;
  logic [dom_pkg::ModeW-1:0]        mode;
  logic [dom_pkg::TagW-1:0]         msg_tag;
  logic [dom_pkg::LenW-1:0]         msg_length;

  modport source (output valid, mode, msg_tag, msg_length, input ready);
  modport sink   (input valid, mode, msg_tag, msg_length, output ready);
endinterface

// Result beat: one per operation
interface dom_out_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       sent_kind;
  logic [dom_pkg::TagW-1:0]         sent_tag;
  logic [dom_pkg::LenW-1:0]         sent_length;
  logic [dom_pkg::CntW-1:0]         dropped_count;
  logic [dom_pkg::CntW-1:0]         queued_count;
  logic [dom_pkg::LenW-1:0]         queued_bytes;

  modport source (output valid, sent_kind, sent_tag, sent_length, dropped_count,
                  queued_count, queued_bytes, input ready);
  modport sink   (input valid, sent_kind, sent_tag, sent_length, dropped_count,
                  queued_count, queued_bytes, output ready);
endinterface

// Register write channel
interface dom_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dom_pkg::CfgIdxW-1:0]      index;
  logic [dom_pkg::LenW-1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/dom_ctrl.sv
`default_nettype none

module dom_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dom_pkg::dp_status_t status_i,
  output dom_pkg::dp_cmd_t         cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LIMIT  = 7'b0000010,
    S_LDROP  = 7'b0000100,
    S_BUDGET = 7'b0001000,
    S_BDROP  = 7'b0010000,
    S_POP    = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.in_valid) begin
          case (status_i.in_mode)
            dom_pkg::MODE_PUSH: state_d = S_LIMIT;
            dom_pkg::MODE_POP:  state_d = S_POP;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_LIMIT: begin
        if (status_i.lim_hit) begin
          state_d = S_LDROP;
        end else begin
          cmd_o.push_write = 1'b1;
          state_d          = S_BUDGET;
        end
      end
      S_LDROP: begin
        cmd_o.drop = 1'b1;
        state_d    = S_LIMIT;
      end
      S_BUDGET: begin
        state_d = status_i.over_budget ? S_BDROP : S_DONE;
      end
      S_BDROP: begin
        cmd_o.drop = 1'b1;
        state_d    = S_BUDGET;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dom_dp.sv
`default_nettype none

`include "drop_oldest_message_queue_core_assert.svh"

module dom_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dom_in_if.sink                 in_i,
  dom_out_if.source              out_o,
  dom_cfg_if.sink                cfg_i,
  input  wire dom_pkg::dp_cmd_t  cmd_i,
  output dom_pkg::dp_status_t    status_o
);

  localparam int PtrW = dom_pkg::PtrW;
  localparam int CntW = dom_pkg::CntW;
  localparam int TagW = dom_pkg::TagW;
  localparam int LenW = dom_pkg::LenW;
  localparam int TotW = dom_pkg::TotW;

  // Registers
  logic [CntW-1:0] max_msg_q;
  logic [LenW-1:0] max_bytes_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [TotW-1:0] total_q, total_d;
  logic            will_valid_q, sub_valid_q;
  logic [TagW-1:0] will_tag_q, sub_tag_q;
  logic [LenW-1:0] will_len_q;

  // Current item and its result
  dom_pkg::mode_e  item_mode_q;
  logic [TagW-1:0] item_tag_q;
  logic [LenW-1:0] item_len_q;
  dom_pkg::kind_e  res_kind_q;
  logic [TagW-1:0] res_tag_q;
  logic [LenW-1:0] res_len_q;
  logic [CntW-1:0] res_drop_q;

  // Output register
  logic            out_valid_q;
  logic [1:0]      out_kind_q;
  logic [TagW-1:0] out_tag_q;
  logic [LenW-1:0] out_len_q;
  logic [CntW-1:0] out_drop_q, out_count_q;
  logic [LenW-1:0] out_bytes_q;

  // Ring memory
  logic [TagW+LenW-1:0] ring_mem [dom_pkg::RingSlots];
  logic [TagW+LenW-1:0] rd_q;
  logic [TagW-1:0]      rd_tag;
  logic [LenW-1:0]      rd_len;

  logic            accept;
  logic            pop_queue;
  logic [CntW-1:0] limit;
  logic [CntW-1:0] ptr_fill;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(dom_pkg::RingSlots - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign accept    = cmd_i.in_ready & in_i.valid;
  assign in_i.ready = cmd_i.in_ready;
  assign cfg_i.ready = 1'b1;
  assign rd_tag    = rd_q[TagW+LenW-1:LenW];
  assign rd_len    = rd_q[LenW-1:0];
  assign pop_queue = cmd_i.pop & ~sub_valid_q & ~will_valid_q & (count_q != '0);

  // Clamp message limit to 1..QueueDepth
  always_comb begin
    if (max_msg_q == '0) begin
      limit = CntW'(1);
    end else if (max_msg_q > CntW'(dom_pkg::QueueDepth)) begin
      limit = CntW'(dom_pkg::QueueDepth);
    end else begin
      limit = max_msg_q;
    end
  end

  // Status to controller
  always_comb begin
    status_o.in_valid    = in_i.valid;
    status_o.in_mode     = dom_pkg::mode_e'(in_i.mode);
    status_o.lim_hit     = count_q >= limit;
    status_o.over_budget = (total_q > {1'b0, max_bytes_q}) && (count_q != '0);
    status_o.out_free    = ~out_valid_q | out_o.ready;
  end

  // Pointer, fill and byte total updates
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    total_d = total_q;
    if (cmd_i.push_write) begin
      head_d  = next_ptr(head_q);
      count_d = count_q + CntW'(1);
      total_d = total_q + {1'b0, item_len_q};
    end else if (cmd_i.drop || pop_queue) begin
      tail_d  = next_ptr(tail_q);
      count_d = count_q - CntW'(1);
      total_d = (total_q >= {1'b0, rd_len}) ? total_q - {1'b0, rd_len} : '0;
    end
  end

  // Ring write at head, registered read at tail
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_write) begin
      ring_mem[head_q] <= {item_tag_q, item_len_q};
    end
    rd_q <= ring_mem[tail_q];
  end

  // Control state and slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_msg_q    <= dom_pkg::MaxMsgReset;
      max_bytes_q  <= dom_pkg::MaxBytesReset;
      head_q       <= '0;
      tail_q       <= '0;
      count_q      <= '0;
      total_q      <= '0;
      will_valid_q <= 1'b0;
      will_tag_q   <= '0;
      will_len_q   <= '0;
      sub_valid_q  <= 1'b0;
      sub_tag_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      total_q <= total_d;
      if (cfg_i.valid) begin
        case (dom_pkg::cfg_reg_e'(cfg_i.index))
          dom_pkg::REG_MAX_MESSAGES: max_msg_q   <= cfg_i.data[CntW-1:0];
          dom_pkg::REG_MAX_BYTES:    max_bytes_q <= cfg_i.data;
          default: ;
        endcase
      end
      if (accept && in_i.mode == dom_pkg::MODE_WILL) begin
        will_valid_q <= 1'b1;
        will_tag_q   <= in_i.msg_tag;
        will_len_q   <= in_i.msg_length;
      end
      if (accept && in_i.mode == dom_pkg::MODE_SUB) begin
        sub_valid_q <= 1'b1;
        sub_tag_q   <= in_i.msg_tag;
      end
      if (cmd_i.pop) begin
        if (sub_valid_q) begin
          sub_valid_q <= 1'b0;
        end else if (will_valid_q) begin
          will_valid_q <= 1'b0;
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item capture and result build
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_mode_q <= dom_pkg::mode_e'(in_i.mode);
      item_tag_q  <= in_i.msg_tag;
      item_len_q  <= in_i.msg_length;
      res_kind_q  <= dom_pkg::KIND_NONE;
      res_tag_q   <= '0;
      res_len_q   <= '0;
      res_drop_q  <= '0;
    end
    if (cmd_i.drop) begin
      res_drop_q <= res_drop_q + CntW'(1);
    end
    if (cmd_i.pop) begin
      if (sub_valid_q) begin
        res_kind_q <= dom_pkg::KIND_SUB;
        res_tag_q  <= sub_tag_q;
      end else if (will_valid_q) begin
        res_kind_q <= dom_pkg::KIND_WILL;
        res_tag_q  <= will_tag_q;
        res_len_q  <= will_len_q;
      end else if (count_q != '0) begin
        res_kind_q <= dom_pkg::KIND_QUEUED;
        res_tag_q  <= rd_tag;
        res_len_q  <= rd_len;
      end
    end
    if (cmd_i.load_out) begin
      out_kind_q  <= res_kind_q;
      out_tag_q   <= res_tag_q;
      out_len_q   <= res_len_q;
      out_drop_q  <= res_drop_q;
      out_count_q <= count_q;
      out_bytes_q <= total_q[TotW-1] ? '1 : total_q[LenW-1:0];
    end
  end

  // Output beat
  assign out_o.valid         = out_valid_q;
  assign out_o.sent_kind     = out_kind_q;
  assign out_o.sent_tag      = out_tag_q;
  assign out_o.sent_length   = out_len_q;
  assign out_o.dropped_count = out_drop_q;
  assign out_o.queued_count  = out_count_q;
  assign out_o.queued_bytes  = out_bytes_q;

  // Fill implied by the ring pointers
  always_comb begin
    if (head_q >= tail_q) begin
      ptr_fill = CntW'(head_q - tail_q);
    end else begin
      ptr_fill = CntW'(PtrW'(dom_pkg::RingSlots) - tail_q + head_q);
    end
  end

  `DOM_ASSERT(a_fill_bound, clk_i, rst_ni, count_q <= CntW'(dom_pkg::QueueDepth), "fill over depth")
  `DOM_ASSERT(a_fill_ptrs, clk_i, rst_ni, count_q == ptr_fill, "fill disagrees with pointers")
  `DOM_ASSERT_IMPL(a_push_budget, clk_i, rst_ni, cmd_i.load_out && item_mode_q == dom_pkg::MODE_PUSH, total_q <= {1'b0, max_bytes_q} || count_q == '0, "push left queue over budget")
  `DOM_ASSERT_NEXT(a_drop_shrinks, clk_i, rst_ni, cmd_i.drop, count_q == $past(count_q) - CntW'(1), "drop did not shrink queue")

endmodule

`default_nettype wire

### rtl/drop_oldest_message_queue_core.sv
// Path from accepting edge to result valid: will or subscription via S_DONE; pop
// via S_POP, S_DONE; push via S_LIMIT, S_BUDGET, an S_LDROP or S_BDROP step per
// dropped entry (each drop reads the oldest length from the ring's registered
// read port, then updates), then S_DONE. One operation at a time; the result
// register lets the next beat be accepted while the previous result waits.
// Reset (async, active low): queue empty, will/subscription clear, limits 32 and 262144.
`default_nettype none

module drop_oldest_message_queue_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dom_in_if.sink    in_i,
  dom_out_if.source out_o,
  dom_cfg_if.sink   cfg_i
);

  dom_pkg::dp_cmd_t    cmd;
  dom_pkg::dp_status_t status;

  dom_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  dom_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

`default_nettype wire
